// ----- hw/rtl/nsa_pkg.sv -----
// nsa_pkg: shared types, codes and constants of the note slot allocator.
// No dependencies; imported by nsa_ctrl, nsa_dp and note_slot_allocator.
`default_nettype none

package nsa_pkg;

  localparam int unsigned SLOT_W        = 7;
  localparam int unsigned DEF_NUM_SLOTS = 127;

  localparam logic [SLOT_W-1:0] NO_SLOT    = 7'h7F;
  localparam logic [6:0]        RESET_BASE = 7'd60;
  localparam logic [7:0]        NOTE_LIMIT = 8'd127;
  localparam logic [6:0]        VEL_CENTRE = 7'd64;
  localparam logic [5:0]        VEL_SCALE  = 6'd63;
  localparam logic signed [15:0] Q_ONE     = 16'sd16384;

  typedef enum logic [1:0] {
    REQ_START    = 2'd0,
    REQ_STOP     = 2'd1,
    REQ_CONTINUE = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic              capture;
    logic              scan_init;
    logic              clear_tbl;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx;
    logic              commit;
  } cmd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/note_slot_allocator.sv -----
// note_slot_allocator: top level; joins sequencer and datapath.
// Depends on nsa_pkg, nsa_ctrl and nsa_dp.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | in_req_type, in_object_id, in_strength,
//          |                      | in_time_us
//  out     | out_valid / out_ready| out_is_note_off, out_note_number,
//          |                      | out_velocity, out_slot_index, out_time_out_us
//  cfg     | cfg_wr_en            | cfg_wr_data (base_note), no wait
//
// Start/stop go through the transfer, one table read per slot through the single
// read port, one drain and one commit; in_ready is back once commit is taken.
// Continue and clear skip the scan; clear drops all slot valid bits at once.
// Commit stalls while a previous result is still held and out_ready is low.
// Reset (rst_n, sync) frees every slot and loads base_note = 60; no sweep.
`default_nettype none

module note_slot_allocator
  import nsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  // input events
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [31:0]        in_object_id,
  input  logic signed [15:0] in_strength,
  input  logic [47:0]        in_time_us,
  // note messages
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_is_note_off,
  output logic [7:0]         out_note_number,
  output logic [6:0]         out_velocity,
  output logic [6:0]         out_slot_index,
  output logic [47:0]        out_time_out_us
);

  cmd_t      cmd;
  req_type_t in_req;

  assign in_req = req_type_t'(in_req_type);

  // sequencer: idle -> scan all slots -> drain last read -> commit
  nsa_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // table, lookup, note/velocity math and the result register
  nsa_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_req          (in_req),
    .in_object_id    (in_object_id),
    .in_strength     (in_strength),
    .in_time_us      (in_time_us),
    .out_is_note_off (out_is_note_off),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_slot_index  (out_slot_index),
    .out_time_out_us (out_time_out_us)
  );

  // a start or stop transfer starts a scan, so the input closes next cycle
  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_START || in_req_type == REQ_STOP)
    |=> !in_ready)
    else $error("input open during slot scan");

  // note-on carries a nonzero velocity, note-off carries zero
  a_velocity_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_note_off ? (out_velocity == 7'd0) : (out_velocity != 7'd0)))
    else $error("velocity does not match message kind");

  // reported slot is a real slot or the none marker
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slot_index < NUM_SLOTS || out_slot_index == NO_SLOT))
    else $error("slot index out of range");

  // a new result only appears with the input closed (work in progress)
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a scan");

endmodule

`default_nettype wire

// ----- hw/rtl/nsa_ctrl.sv -----
// nsa_ctrl: sequencer for the slot scan, commit and output valid.
// Depends on nsa_pkg (state_t, req_type_t, cmd_t).
`default_nettype none

module nsa_ctrl
  import nsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  req_type_t in_req,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output cmd_t      cmd
);

  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && (in_req inside {REQ_START, REQ_STOP})) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = in_valid;
        cmd.scan_init = in_valid;
        cmd.clear_tbl = in_valid && (in_req == REQ_CLEAR);
      end
      S_SCAN: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = cnt_r;
      end
      S_DRAIN: begin
        cmd.rd_en = 1'b0;
      end
      S_COMMIT: begin
        cmd.commit = !out_valid_r || out_ready;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- hw/rtl/nsa_dp.sv -----
// nsa_dp: slot table memory, match/free tracking, note and velocity math,
// output payload registers. Depends on nsa_pkg (cmd_t, codes, constants).
`default_nettype none

module nsa_dp
  import nsa_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = DEF_NUM_SLOTS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data,
  input  req_type_t          in_req,
  input  logic [31:0]        in_object_id,
  input  logic signed [15:0] in_strength,
  input  logic [47:0]        in_time_us,
  output logic               out_is_note_off,
  output logic [7:0]         out_note_number,
  output logic [6:0]         out_velocity,
  output logic [SLOT_W-1:0]  out_slot_index,
  output logic [47:0]        out_time_out_us
);

  localparam int unsigned AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // captured item
  req_type_t          req_r;
  logic [31:0]        id_r;
  logic signed [15:0] str_r;
  logic [47:0]        time_r;
  logic [6:0]         base_r;

  // table: data in memory, per-entry valid in flops (invalid reads as zero)
  logic [31:0]        mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;
  logic [31:0]        rd_data_r;
  logic               rd_ent_vld_r;
  logic               rd_vld_r;
  logic [SLOT_W-1:0]  rd_idx_r;

  logic               match_found_r, free_found_r;
  logic [SLOT_W-1:0]  match_idx_r, free_idx_r;

  logic [31:0]        entry;
  logic               do_claim;
  logic               do_free;
  logic [SLOT_W-1:0]  res_slot;
  logic [7:0]         sum8, note;
  logic signed [15:0] s_clamp;
  logic               s_neg;
  logic [14:0]        s_abs;
  logic [20:0]        prod;
  logic [6:0]         mag;
  logic [6:0]         vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= RESET_BASE;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req;
      id_r   <= in_object_id;
      str_r  <= in_strength;
      time_r <= in_time_us;
    end
  end

  // memory port: registered read, write on claim
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_idx[AW-1:0]];
    end
    if (do_claim) begin
      mem[free_idx_r[AW-1:0]] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      rd_vld_r     <= 1'b0;
      rd_ent_vld_r <= 1'b0;
      rd_idx_r     <= '0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      if (cmd.rd_en) begin
        rd_ent_vld_r <= valid_r[cmd.rd_idx[AW-1:0]];
        rd_idx_r     <= cmd.rd_idx;
      end
      if (cmd.clear_tbl) begin
        valid_r <= '0;
      end else if (do_claim) begin
        valid_r[free_idx_r[AW-1:0]] <= 1'b1;
      end else if (do_free) begin
        valid_r[match_idx_r[AW-1:0]] <= 1'b0;
      end
    end
  end

  assign entry = rd_ent_vld_r ? rd_data_r : 32'd0;

  // first match and first free, in address order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      match_idx_r   <= NO_SLOT;
      free_idx_r    <= NO_SLOT;
    end else if (cmd.scan_init) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      match_idx_r   <= NO_SLOT;
      free_idx_r    <= NO_SLOT;
    end else if (rd_vld_r) begin
      if (!match_found_r && (entry == id_r)) begin
        match_found_r <= 1'b1;
        match_idx_r   <= rd_idx_r;
      end
      if (!free_found_r && (entry == 32'd0)) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  assign do_claim = cmd.commit && (req_r == REQ_START) && !match_found_r && free_found_r;
  assign do_free  = cmd.commit && (req_r == REQ_STOP) && match_found_r;

  always_comb begin
    if (match_found_r) begin
      res_slot = match_idx_r;
    end else if ((req_r == REQ_START) && free_found_r) begin
      res_slot = free_idx_r;
    end else begin
      res_slot = NO_SLOT;
    end
  end

  // note: base + slot, folded down to base - slot at the top of the range
  assign sum8 = {1'b0, base_r} + {1'b0, res_slot};
  assign note = (sum8 >= NOTE_LIMIT) ? ({1'b0, base_r} - {1'b0, res_slot}) : sum8;

  // velocity: clamp to +-1.0, scale by 63, truncate toward zero, recenter
  always_comb begin
    if (str_r < -Q_ONE) begin
      s_clamp = -Q_ONE;
    end else if (str_r > Q_ONE) begin
      s_clamp = Q_ONE;
    end else begin
      s_clamp = str_r;
    end
  end

  assign s_neg = s_clamp[15];
  assign s_abs = s_neg ? 15'(-s_clamp) : s_clamp[14:0];
  assign prod  = 21'(s_abs) * 21'(VEL_SCALE);
  assign mag   = {1'b0, prod[19:14]};
  assign vel   = s_neg ? (VEL_CENTRE - mag) : (VEL_CENTRE + mag);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_is_note_off <= (req_r == REQ_STOP);
      out_note_number <= note;
      out_velocity    <= (req_r == REQ_STOP) ? 7'd0 : vel;
      out_slot_index  <= res_slot;
      out_time_out_us <= time_r;
    end
  end

endmodule

`default_nettype wire
